FILE: design/bsfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_pkg
// Shared types and constants of the byte stuffed frame builder.
// ----------------------------------------------------------------------------
package bsfb_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FLAG_VALUE        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_VALUE      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FLAG_SUBSTITUTE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_SUBSTITUTE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ADDRESS_VALUE     = 3'd4;

  // Reset values of the configuration registers
  localparam logic [ByteW-1:0] FlagReset     = 8'h7E;
  localparam logic [ByteW-1:0] EscapeReset   = 8'h7D;
  localparam logic [ByteW-1:0] FlagSubReset  = 8'h5E;
  localparam logic [ByteW-1:0] EscSubReset   = 8'h5D;
  localparam logic [ByteW-1:0] AddressReset  = 8'h03;

  typedef struct packed {
    logic [ByteW-1:0] flag_value;
    logic [ByteW-1:0] escape_value;
    logic [ByteW-1:0] flag_substitute;
    logic [ByteW-1:0] escape_substitute;
    logic [ByteW-1:0] address_value;
  } cfg_t;

  // One outgoing line beat
  typedef struct packed {
    logic [ByteW-1:0] line_byte;
    logic             run_end;
    logic             frame_end;
  } beat_t;

  // Field of the frame being emitted
  typedef enum logic [2:0] {
    SLOT_OPEN,
    SLOT_ADDR,
    SLOT_CTRL,
    SLOT_HCHK,
    SLOT_PAY,
    SLOT_TCHK,
    SLOT_CLOSE
  } slot_e;

endpackage : bsfb_pkg
`default_nettype wire

FILE: design/bsfb_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_seq
// Item register and field sequencer: expands one item into stuffed beats.
// ----------------------------------------------------------------------------
module bsfb_seq
  import bsfb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [ByteW-1:0] payload_byte_i,
  input  wire logic [ByteW-1:0] control_byte_i,
  input  wire logic             final_byte_i,
  output      logic             beat_valid_o,
  input  wire logic             beat_ready_i,
  output      beat_t            beat_o
);

  // Frame state
  logic             inside_q, inside_d;
  logic [ByteW-1:0] trailer_q, trailer_d;

  // Item register
  logic             item_valid_q, item_valid_d;
  logic [ByteW-1:0] pay_q, ctrl_q, tchk_q;
  logic             final_q;
  slot_e            slot_q, slot_d;
  logic             half_q, half_d;

  logic             accept;
  logic             emit;
  logic             advance;
  logic             last_beat;
  logic [ByteW-1:0] raw;
  logic             stuffable;
  logic             is_flag;
  logic             is_esc;
  logic [ByteW-1:0] base_chk;
  slot_e            slot_nxt;

  assign accept = in_valid_i && in_ready_o;
  assign emit   = item_valid_q && beat_ready_i;

  always_comb begin
    raw       = cfg_i.flag_value;
    stuffable = 1'b1;
    slot_nxt  = SLOT_OPEN;
    unique case (slot_q)
      SLOT_OPEN: begin
        raw       = cfg_i.flag_value;
        stuffable = 1'b0;
        slot_nxt  = SLOT_ADDR;
      end
      SLOT_ADDR: begin
        raw      = cfg_i.address_value;
        slot_nxt = SLOT_CTRL;
      end
      SLOT_CTRL: begin
        raw      = ctrl_q;
        slot_nxt = SLOT_HCHK;
      end
      SLOT_HCHK: begin
        raw      = cfg_i.address_value ^ ctrl_q;
        slot_nxt = SLOT_PAY;
      end
      SLOT_PAY: begin
        raw      = pay_q;
        slot_nxt = SLOT_TCHK;
      end
      SLOT_TCHK: begin
        raw      = tchk_q;
        slot_nxt = SLOT_CLOSE;
      end
      SLOT_CLOSE: begin
        raw       = cfg_i.flag_value;
        stuffable = 1'b0;
        slot_nxt  = SLOT_OPEN;
      end
      default: begin
        raw       = cfg_i.flag_value;
        stuffable = 1'b0;
        slot_nxt  = SLOT_OPEN;
      end
    endcase
  end

  assign is_flag = (raw == cfg_i.flag_value);
  assign is_esc  = (raw == cfg_i.escape_value);

  always_comb begin
    beat_o.line_byte = raw;
    advance          = 1'b1;
    if (stuffable && (is_flag || is_esc)) begin
      if (!half_q) begin
        beat_o.line_byte = cfg_i.escape_value;
        advance          = 1'b0;
      end else if (is_flag) begin
        beat_o.line_byte = cfg_i.flag_substitute;
      end else begin
        beat_o.line_byte = cfg_i.escape_substitute;
      end
    end
    last_beat = advance &&
                ((slot_q == SLOT_CLOSE) || ((slot_q == SLOT_PAY) && !final_q));
    beat_o.run_end   = last_beat;
    beat_o.frame_end = (slot_q == SLOT_CLOSE);
  end

  assign beat_valid_o = item_valid_q;
  assign in_ready_o   = !item_valid_q || (emit && last_beat);

  // Frame state moves at accept time, so the next item sees it at once
  assign base_chk  = inside_q ? trailer_q : '0;
  assign inside_d  = accept ? !final_byte_i : inside_q;
  assign trailer_d = accept ? (final_byte_i ? '0 : (base_chk ^ payload_byte_i)) : trailer_q;

  always_comb begin
    item_valid_d = item_valid_q;
    slot_d       = slot_q;
    half_d       = half_q;
    if (emit) begin
      if (last_beat) begin
        item_valid_d = 1'b0;
      end else if (advance) begin
        slot_d = slot_nxt;
        half_d = 1'b0;
      end else begin
        half_d = 1'b1;
      end
    end
    if (accept) begin
      item_valid_d = 1'b1;
      slot_d       = inside_q ? SLOT_PAY : SLOT_OPEN;
      half_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q     <= 1'b0;
      trailer_q    <= '0;
      item_valid_q <= 1'b0;
      slot_q       <= SLOT_OPEN;
      half_q       <= 1'b0;
    end else begin
      inside_q     <= inside_d;
      trailer_q    <= trailer_d;
      item_valid_q <= item_valid_d;
      slot_q       <= slot_d;
      half_q       <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pay_q   <= payload_byte_i;
      ctrl_q  <= control_byte_i;
      final_q <= final_byte_i;
      tchk_q  <= base_chk ^ payload_byte_i;
    end
  end

`ifndef NO_ASSERTIONS
  // The second half of a stuffed pair never falls on a delimiter flag
  a_half_stuffable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> (slot_q != SLOT_OPEN) && (slot_q != SLOT_CLOSE))
    else $error("stuffing half set on a delimiter");

  // The closing flag always ends the run of its item
  a_close_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && (slot_q == SLOT_CLOSE)) |-> last_beat)
    else $error("closing flag not last beat");

  // A frame left open by an item means the next item starts at the payload
  a_open_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !final_byte_i) |=> inside_q)
    else $error("frame state not kept open");
`endif

endmodule : bsfb_seq
`default_nettype wire

FILE: design/bsfb_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_out
// Output register: holds one line beat until the sink takes it.
// ----------------------------------------------------------------------------
module bsfb_out
  import bsfb_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  beat_valid_i,
  output      logic  beat_ready_o,
  input  wire beat_t beat_i,
  output      logic  out_valid_o,
  input  wire logic  out_ready_i,
  output      beat_t beat_o
);

  logic  valid_q, valid_d;
  beat_t beat_q;

  // Take a new beat when empty or when the held beat leaves this cycle
  assign beat_ready_o = !valid_q || out_ready_i;
  assign valid_d      = beat_ready_o ? beat_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_ready_o && beat_valid_i) begin
      beat_q <= beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign beat_o      = beat_q;

endmodule : bsfb_out
`default_nettype wire

FILE: design/byte_stuffed_frame_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffed_frame_builder
// HDLC-style framer: opening flag, stuffed header, stuffed payload, XOR
// trailer check and closing flag.
// ----------------------------------------------------------------------------
// Each accepted payload beat turns into one to twelve line beats, sent one
// per clock while the sink takes them: the first beat of a frame adds the
// opening flag, the address, control and header check bytes, and a beat
// marked final adds the trailer check and the closing flag; every byte
// except the two flags is stuffed (flag or escape byte sent as escape plus
// substitute). An item holds the block until it has sent its last line
// beat; the single output byte register moves one byte per cycle while the
// sink is ready, and a stuffed payload byte yields two line beats. The next
// input beat is taken in the cycle the current item sends its last line
// beat. The first line beat of an item passes through the item register
// and then the output register before it shows on the output. run_end_o
// marks the last line beat of each input beat, frame_end_o the closing
// flag. Write configuration only while idle.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_builder
  import bsfb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  // payload beats in
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [ByteW-1:0]   payload_byte_i,
  input  wire logic [ByteW-1:0]   control_byte_i,
  input  wire logic               final_byte_i,
  // line beats out
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [ByteW-1:0]   line_byte_o,
  output      logic               run_end_o,
  output      logic               frame_end_o
);

  cfg_t  cfg_q, cfg_d;
  logic  beat_valid;
  logic  beat_ready;
  beat_t seq_beat;
  beat_t out_beat;

  // Register file: drop writes to unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLAG_VALUE:        cfg_d.flag_value        = cfg_data_i;
        CFG_ESCAPE_VALUE:      cfg_d.escape_value      = cfg_data_i;
        CFG_FLAG_SUBSTITUTE:   cfg_d.flag_substitute   = cfg_data_i;
        CFG_ESCAPE_SUBSTITUTE: cfg_d.escape_substitute = cfg_data_i;
        CFG_ADDRESS_VALUE:     cfg_d.address_value     = cfg_data_i;
        default:               cfg_d                   = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_value        <= FlagReset;
      cfg_q.escape_value      <= EscapeReset;
      cfg_q.flag_substitute   <= FlagSubReset;
      cfg_q.escape_substitute <= EscSubReset;
      cfg_q.address_value     <= AddressReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Expand each item into line beats, one field or half of a stuffed pair
  // per cycle while the output register takes them
  bsfb_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .payload_byte_i (payload_byte_i),
    .control_byte_i (control_byte_i),
    .final_byte_i   (final_byte_i),
    .beat_valid_o   (beat_valid),
    .beat_ready_i   (beat_ready),
    .beat_o         (seq_beat)
  );

  // Hold each line beat until the sink takes it
  bsfb_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_ready_o (beat_ready),
    .beat_i       (seq_beat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .beat_o       (out_beat)
  );

  assign line_byte_o = out_beat.line_byte;
  assign run_end_o   = out_beat.run_end;
  assign frame_end_o = out_beat.frame_end;

endmodule : byte_stuffed_frame_builder
`default_nettype wire
